### rtl/core/grid_triangle_index_gen_defines.svh
// Assertion macros shared by the grid index generator modules.
// The enclosing module provides i_clk and i_rst_n.
`ifndef GRID_TRIANGLE_INDEX_GEN_DEFINES_SVH
`define GRID_TRIANGLE_INDEX_GEN_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GTIG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define GTIG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GTIG_ASSERT(label, prop, msg)
`define GTIG_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### rtl/core/gtig_pkg.sv
`timescale 1ns / 1ps

package gtig_pkg;

    localparam int IDX_W       = 13;
    localparam int LEVEL_REG_W = 7;
    localparam int COORD_W     = 6;
    localparam int CNT_W       = 3;
    localparam int DEF_MAX_LEVEL = 64;

    typedef enum logic {
        FUNC_CELL = 1'b0,
        FUNC_EDGE = 1'b1
    } t_func;

    localparam logic [CNT_W-1:0] CELL_LAST_K = 3'd5;
    localparam logic [CNT_W-1:0] EDGE_LAST_K = 3'd7;
    localparam logic [CNT_W-1:0] BAD_LAST_K  = 3'd0;

    // Everything the emitter needs for one request, all modulo 2^IDX_W.
    typedef struct packed {
        t_func              func;
        logic               bad;
        logic               flip;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   level;
        logic [IDX_W-1:0]   stride;
        logic [IDX_W-1:0]   bottom;
        logic [IDX_W-1:0]   row_base;
        logic [IDX_W-1:0]   cell_a;
    } t_job;

endpackage

### rtl/core/gtig_intf.sv
`timescale 1ns / 1ps

interface gtig_req_if;
    import gtig_pkg::*;
    logic                valid;
    logic                ready;
    t_func               func;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    modport source (output valid, func, row, col, input ready);
    modport sink   (input valid, func, row, col, output ready);
endinterface

interface gtig_res_if;
    import gtig_pkg::*;
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    vertex_index;
    logic                last;
    logic                bad_coord;
    modport source (output valid, vertex_index, last, bad_coord, input ready);
    modport sink   (input valid, vertex_index, last, bad_coord, output ready);
endinterface

interface gtig_cfg_if;
    import gtig_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [LEVEL_REG_W-1:0] tess_level;
    modport source (output valid, tess_level, input ready);
    modport sink   (input valid, tess_level, output ready);
endinterface

### rtl/core/gtig_emitter.sv
`timescale 1ns / 1ps
`include "grid_triangle_index_gen_defines.svh"

module gtig_emitter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  gtig_pkg::t_job    i_job,
    output logic              o_job_ready,
    gtig_res_if.source        o_res
);
    import gtig_pkg::*;

    t_job               r_job;
    logic               r_job_valid;
    logic [CNT_W-1:0]   r_k;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_idx;
    logic               r_last;
    logic               r_bad;

    logic [CNT_W-1:0]   last_k;
    logic               last_step;
    logic               out_take;
    logic               step;
    logic [IDX_W-1:0]   n_idx;
    logic [IDX_W-1:0]   cell_b;

    always_comb begin
        if (r_job.bad) begin
            last_k = BAD_LAST_K;
        end else if (r_job.func == FUNC_EDGE) begin
            last_k = EDGE_LAST_K;
        end else begin
            last_k = CELL_LAST_K;
        end
    end

    assign last_step   = (r_k == last_k);
    assign out_take    = !r_out_valid || o_res.ready;
    assign step        = r_job_valid && out_take;
    assign o_job_ready = !r_job_valid || (step && last_step);
    assign cell_b      = r_job.cell_a + r_job.stride;

    // The flipped cell uses the other diagonal, so its triangle order differs.
    always_comb begin
        n_idx = '0;
        if (r_job.bad) begin
            n_idx = '0;
        end else if (r_job.func == FUNC_EDGE) begin
            case (r_k)
                3'd0:    n_idx = r_job.row;
                3'd1:    n_idx = r_job.row + 1'b1;
                3'd2:    n_idx = r_job.bottom + r_job.row;
                3'd3:    n_idx = r_job.bottom + r_job.row + 1'b1;
                3'd4:    n_idx = r_job.row_base;
                3'd5:    n_idx = r_job.row_base + r_job.stride;
                3'd6:    n_idx = r_job.row_base + r_job.level;
                default: n_idx = r_job.row_base + r_job.stride + r_job.level;
            endcase
        end else if (r_job.flip) begin
            case (r_k)
                3'd0:    n_idx = r_job.cell_a;
                3'd1:    n_idx = cell_b;
                3'd2:    n_idx = cell_b + 1'b1;
                3'd3:    n_idx = cell_b + 1'b1;
                3'd4:    n_idx = r_job.cell_a + 1'b1;
                default: n_idx = r_job.cell_a;
            endcase
        end else begin
            case (r_k)
                3'd0:    n_idx = r_job.cell_a + 1'b1;
                3'd1:    n_idx = r_job.cell_a;
                3'd2:    n_idx = cell_b;
                3'd3:    n_idx = cell_b;
                3'd4:    n_idx = cell_b + 1'b1;
                default: n_idx = r_job.cell_a + 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_k         <= '0;
        end else if (i_job_valid && o_job_ready) begin
            r_job_valid <= 1'b1;
            r_k         <= '0;
        end else if (step && last_step) begin
            r_job_valid <= 1'b0;
            r_k         <= '0;
        end else if (step) begin
            r_k <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid && o_job_ready) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_idx  <= n_idx;
            r_last <= last_step;
            r_bad  <= r_job.bad;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.vertex_index = r_idx;
    assign o_res.last         = r_last;
    assign o_res.bad_coord    = r_bad;

    `GTIG_ASSERT(a_k_in_range, !r_job_valid || (r_k <= last_k), "step counter past request end")
    `GTIG_ASSERT(a_bad_single, !(r_out_valid && r_bad) || (r_last && (r_idx == '0)), "bad result not single zero")
    `GTIG_ASSERT_NEXT(a_job_continues, step && !last_step, r_job_valid, "job dropped before last index")
    `GTIG_ASSERT_NEXT(a_out_filled, step, r_out_valid, "emitted index not presented")

endmodule

### rtl/core/grid_triangle_index_gen.sv
`timescale 1ns / 1ps
// Channel   Modport         Payload                            Purpose
// i_req     sink            func, row, col                     cell or boundary request
// o_res     source          vertex_index, last, bad_coord      one index per transaction
// i_cfg     sink            tess_level                         level register write
//
// A cell request produces six results, a boundary request eight, a bad coordinate one.
// The result channel carries one index per cycle while o_res is ready.
// A request passes through the input register, the job register and the output register.
// The next request is taken while the current one emits, so results stream without gaps.
// Reset is synchronous and active low; the level resets to 1. Stalls on o_res back up to i_req.
`include "grid_triangle_index_gen_defines.svh"

module grid_triangle_index_gen #(
    parameter int MAX_LEVEL = gtig_pkg::DEF_MAX_LEVEL
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gtig_req_if.sink    i_req,
    gtig_res_if.source  o_res,
    gtig_cfg_if.sink    i_cfg
);
    import gtig_pkg::*;

    localparam int LVL_W = $clog2(MAX_LEVEL + 2);
    localparam int SAT_W = (LVL_W > LEVEL_REG_W) ? LVL_W : LEVEL_REG_W;
    localparam int CMP_W = (LVL_W > COORD_W) ? LVL_W : COORD_W;

    logic [LVL_W-1:0]   r_level;
    logic [IDX_W-1:0]   r_bottom;
    logic [LVL_W-1:0]   n_level;
    logic [IDX_W-1:0]   n_bottom;
    logic [SAT_W-1:0]   cfg_ext;

    logic               r_in_valid;
    t_func              r_func;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_col;

    logic               job_ready;
    t_job               job;
    logic [CMP_W-1:0]   row_c;
    logic [CMP_W-1:0]   col_c;
    logic [CMP_W-1:0]   lvl_c;
    logic [CMP_W-1:0]   half_c;
    logic [IDX_W-1:0]   lvl_i;
    logic [IDX_W-1:0]   stride_i;
    logic [IDX_W-1:0]   row_base;

    // Level saturates to MAX_LEVEL; the bottom row start (L+1)*L follows it.
    assign cfg_ext  = SAT_W'(i_cfg.tess_level);
    assign n_level  = (cfg_ext > SAT_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : LVL_W'(cfg_ext);
    assign n_bottom = IDX_W'((IDX_W'(n_level) + 1'b1) * IDX_W'(n_level));
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= LVL_W'(1);
            r_bottom <= IDX_W'(2);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_level  <= n_level;
            r_bottom <= n_bottom;
        end
    end

    assign i_req.ready = !r_in_valid || job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (job_ready) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_func <= i_req.func;
            r_row  <= i_req.row;
            r_col  <= i_req.col;
        end
    end

    assign row_c    = CMP_W'(r_row);
    assign col_c    = CMP_W'(r_col);
    assign lvl_c    = CMP_W'(r_level);
    assign half_c   = lvl_c >> 1;
    assign lvl_i    = IDX_W'(r_level);
    assign stride_i = lvl_i + 1'b1;
    assign row_base = IDX_W'(IDX_W'(r_row) * stride_i);

    always_comb begin
        job.func     = r_func;
        job.bad      = (row_c >= lvl_c) || ((r_func == FUNC_CELL) && (col_c >= lvl_c));
        job.flip     = (row_c < half_c) != (col_c < half_c);
        job.row      = IDX_W'(r_row);
        job.level    = lvl_i;
        job.stride   = stride_i;
        job.bottom   = r_bottom;
        job.row_base = row_base;
        job.cell_a   = row_base + IDX_W'(r_col);
    end

    gtig_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (r_in_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_res       (o_res)
    );

    `GTIG_ASSERT(a_level_sat, r_level <= LVL_W'(MAX_LEVEL), "level above maximum")
    `GTIG_ASSERT(a_bottom_match, r_bottom == IDX_W'((lvl_i + 1'b1) * lvl_i), "bottom row base stale")
    `GTIG_ASSERT_NEXT(a_hold_pending, r_in_valid && !job_ready, r_in_valid, "pending request lost")

endmodule
